### rtl/core/dpsoc_pkg.sv
package dpsoc_pkg;

   localparam int MAX_NODES = 4096;
   localparam int MAX_TEXT  = 1024;
   localparam int ALPHABET  = 26;

   localparam int NODE_W   = $clog2(MAX_NODES);
   localparam int LET_W    = 5;
   localparam int CHILD_AW = NODE_W + LET_W;
   localparam int CNT_W    = NODE_W + 1;
   localparam int TEXT_AW  = $clog2(MAX_TEXT);
   localparam int LEN_W    = TEXT_AW + 1;
   localparam int WT_W     = 16;
   localparam int SUM_W    = 40;
   localparam int TOT_W    = 32;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_POOL_FULL = 2'd1;
   localparam logic [1:0] STAT_TEXT_LONG = 2'd2;

   typedef struct packed {
      logic clear_en;
      logic ins_take;
      logic ins_check;
      logic wt_update;
      logic qry_take;
      logic q_begin;
      logic q_start;
      logic q_char;
      logic q_step;
      logic q_acc;
      logic next_start;
      logic q_done;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic ins_go;
      logic last;
      logic err_nz;
      logic start_end;
      logic pos_end;
      logic char_bad;
      logic child_zero;
   } stat_type;

endpackage

### rtl/core/dpsoc_dp.sv
module dpsoc_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  dpsoc_pkg::cmd_type       cmd,
   output dpsoc_pkg::stat_type      stat,
   input  logic [1:0]               req_opcode,
   input  logic [4:0]               req_letter,
   input  logic                     req_last,
   output logic signed [31:0]       rsp_occurrence_total,
   output logic [1:0]               rsp_status
);
   import dpsoc_pkg::*;

   logic [NODE_W-1:0] child_mem [2**CHILD_AW];
   logic [WT_W-1:0]   weight_mem [MAX_NODES];
   logic [LET_W-1:0]  text_mem [MAX_TEXT];

   logic [NODE_W-1:0]   child_rd_ff;
   logic [WT_W-1:0]     weight_rd_ff;
   logic [LET_W-1:0]    text_rd_ff;

   logic [CHILD_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NODE_W-1:0]   cursor_ff, cursor_in;
   logic                blocked_ff, blocked_in;
   logic [1:0]          err_ff, err_in;
   logic [CNT_W-1:0]    nodes_ff, nodes_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    start_ff, start_in;
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [1:0]          op_ff, op_in;
   logic                last_ff, last_in;
   logic [CHILD_AW-1:0] ins_addr_ff, ins_addr_in;
   logic signed [TOT_W-1:0] res_total_ff, res_total_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic signed [TOT_W-1:0] rsp_total_ff, rsp_total_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic [CHILD_AW-1:0] child_raddr;
   logic [NODE_W-1:0]   weight_raddr;
   logic                child_we;
   logic [CHILD_AW-1:0] child_waddr;
   logic [NODE_W-1:0]   child_wdata;
   logic                weight_we;
   logic [NODE_W-1:0]   weight_waddr;
   logic [WT_W-1:0]     weight_wdata;
   logic                text_we;
   logic signed [WT_W-1:0] w_old;
   logic signed [WT_W-1:0] w_new;
   logic signed [TOT_W-1:0] sum_sat;

   assign child_raddr  = cmd.q_char ? {node_ff, text_rd_ff} : {cursor_ff, req_letter};
   assign weight_raddr = cmd.q_step ? child_rd_ff : cursor_ff;

   assign w_old = $signed(weight_rd_ff);

   always_comb begin
      if (op_ff == OP_ADD) begin
         w_new = (w_old == 16'sh7FFF) ? w_old : w_old + 16'sd1;
      end else begin
         w_new = (w_old == -16'sh8000) ? w_old : w_old - 16'sd1;
      end
   end

   always_comb begin
      if (sum_ff > $signed(40'sh007FFFFFFF)) begin
         sum_sat = 32'sh7FFFFFFF;
      end else if (sum_ff < -$signed(40'sh0080000000)) begin
         sum_sat = -32'sh80000000;
      end else begin
         sum_sat = sum_ff[TOT_W-1:0];
      end
   end

   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      cursor_in     = cursor_ff;
      blocked_in    = blocked_ff;
      err_in        = err_ff;
      nodes_in      = nodes_ff;
      len_in        = len_ff;
      start_in      = start_ff;
      pos_in        = pos_ff;
      node_in       = node_ff;
      sum_in        = sum_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      ins_addr_in   = ins_addr_ff;
      res_total_in  = res_total_ff;
      res_status_in = res_status_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      child_we      = 1'b0;
      child_waddr   = clr_cnt_ff;
      child_wdata   = '0;
      weight_we     = 1'b0;
      weight_waddr  = clr_cnt_ff[NODE_W-1:0];
      weight_wdata  = '0;
      text_we       = 1'b0;

      if (cmd.clear_en) begin
         child_we   = 1'b1;
         weight_we  = 1'b1;
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end

      if (cmd.ins_take) begin
         op_in       = req_opcode;
         last_in     = req_last;
         ins_addr_in = {cursor_ff, req_letter};
      end

      if (cmd.ins_check) begin
         if (child_rd_ff == '0) begin
            if (nodes_ff >= CNT_W'(MAX_NODES)) begin
               blocked_in = 1'b1;
               if (err_ff == STAT_OK) begin
                  err_in = STAT_POOL_FULL;
               end
            end else begin
               child_we    = 1'b1;
               child_waddr = ins_addr_ff;
               child_wdata = nodes_ff[NODE_W-1:0];
               cursor_in   = nodes_ff[NODE_W-1:0];
               nodes_in    = nodes_ff + 1'b1;
            end
         end else begin
            cursor_in = child_rd_ff;
         end
      end

      if (cmd.wt_update) begin
         if (!blocked_ff && err_ff == STAT_OK) begin
            weight_we    = 1'b1;
            weight_waddr = cursor_ff;
            weight_wdata = w_new;
         end
         res_total_in  = '0;
         res_status_in = err_ff;
         cursor_in     = '0;
         blocked_in    = 1'b0;
         err_in        = STAT_OK;
      end

      if (cmd.qry_take) begin
         if (len_ff >= LEN_W'(MAX_TEXT)) begin
            if (err_ff == STAT_OK) begin
               err_in = STAT_TEXT_LONG;
            end
         end else begin
            text_we = 1'b1;
            len_in  = len_ff + 1'b1;
         end
      end

      if (cmd.q_begin) begin
         start_in = '0;
         sum_in   = '0;
      end

      if (cmd.q_start) begin
         pos_in  = start_ff;
         node_in = '0;
      end

      if (cmd.next_start) begin
         start_in = start_ff + 1'b1;
      end

      if (cmd.q_step) begin
         node_in = child_rd_ff;
      end

      if (cmd.q_acc) begin
         sum_in = sum_ff + SUM_W'(w_old);
         pos_in = pos_ff + 1'b1;
      end

      if (cmd.q_done) begin
         res_total_in  = sum_sat;
         res_status_in = err_ff;
         err_in        = STAT_OK;
         len_in        = '0;
      end

      if (cmd.load_rsp) begin
         rsp_total_in  = res_total_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      child_rd_ff <= child_mem[child_raddr];
   end

   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[weight_waddr] <= weight_wdata;
      end
      weight_rd_ff <= weight_mem[weight_raddr];
   end

   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[len_ff[TEXT_AW-1:0]] <= req_letter;
      end
      text_rd_ff <= text_mem[pos_ff[TEXT_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         cursor_ff  <= '0;
         blocked_ff <= 1'b0;
         err_ff     <= STAT_OK;
         nodes_ff   <= CNT_W'(1);
         len_ff     <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         cursor_ff  <= cursor_in;
         blocked_ff <= blocked_in;
         err_ff     <= err_in;
         nodes_ff   <= nodes_in;
         len_ff     <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      pos_ff        <= pos_in;
      node_ff       <= node_in;
      sum_ff        <= sum_in;
      op_ff         <= op_in;
      last_ff       <= last_in;
      ins_addr_ff   <= ins_addr_in;
      res_total_ff  <= res_total_in;
      res_status_ff <= res_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign stat.clr_last   = (clr_cnt_ff == '1);
   assign stat.ins_go     = !blocked_ff && (req_letter < LET_W'(ALPHABET));
   assign stat.last       = last_ff;
   assign stat.err_nz     = (err_ff != STAT_OK);
   assign stat.start_end  = (start_ff >= len_ff);
   assign stat.pos_end    = (pos_ff >= len_ff);
   assign stat.char_bad   = (text_rd_ff >= LET_W'(ALPHABET));
   assign stat.child_zero = (child_rd_ff == '0);

   assign rsp_occurrence_total = rsp_total_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

### rtl/core/dpsoc_ctrl.sv
module dpsoc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dpsoc_pkg::stat_type  stat,
   output dpsoc_pkg::cmd_type   cmd
);
   import dpsoc_pkg::*;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_INS_CHK = 4'd2;
   localparam logic [3:0] S_WT_RD   = 4'd3;
   localparam logic [3:0] S_WT_WR   = 4'd4;
   localparam logic [3:0] S_Q_BEGIN = 4'd5;
   localparam logic [3:0] S_Q_START = 4'd6;
   localparam logic [3:0] S_Q_TXT   = 4'd7;
   localparam logic [3:0] S_Q_CH    = 4'd8;
   localparam logic [3:0] S_Q_NX    = 4'd9;
   localparam logic [3:0] S_Q_WT    = 4'd10;
   localparam logic [3:0] S_Q_DONE  = 4'd11;
   localparam logic [3:0] S_OUT     = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_ADD || req_opcode == OP_REMOVE) begin
                  cmd.ins_take = 1'b1;
                  if (stat.ins_go) begin
                     state_in = S_INS_CHK;
                  end else if (req_last) begin
                     state_in = S_WT_RD;
                  end
               end else if (req_opcode == OP_QUERY) begin
                  cmd.qry_take = 1'b1;
                  if (req_last) begin
                     state_in = S_Q_BEGIN;
                  end
               end
            end
         end
         S_INS_CHK: begin
            cmd.ins_check = 1'b1;
            state_in = stat.last ? S_WT_RD : S_IDLE;
         end
         S_WT_RD: begin
            state_in = S_WT_WR;
         end
         S_WT_WR: begin
            cmd.wt_update = 1'b1;
            state_in = S_OUT;
         end
         S_Q_BEGIN: begin
            cmd.q_begin = 1'b1;
            state_in = stat.err_nz ? S_Q_DONE : S_Q_START;
         end
         S_Q_START: begin
            if (stat.start_end) begin
               state_in = S_Q_DONE;
            end else begin
               cmd.q_start = 1'b1;
               state_in = S_Q_TXT;
            end
         end
         S_Q_TXT: begin
            if (stat.pos_end) begin
               cmd.next_start = 1'b1;
               state_in = S_Q_START;
            end else begin
               state_in = S_Q_CH;
            end
         end
         S_Q_CH: begin
            if (stat.char_bad) begin
               cmd.next_start = 1'b1;
               state_in = S_Q_START;
            end else begin
               cmd.q_char = 1'b1;
               state_in = S_Q_NX;
            end
         end
         S_Q_NX: begin
            if (stat.child_zero) begin
               cmd.next_start = 1'b1;
               state_in = S_Q_START;
            end else begin
               cmd.q_step = 1'b1;
               state_in = S_Q_WT;
            end
         end
         S_Q_WT: begin
            cmd.q_acc = 1'b1;
            state_in = S_Q_TXT;
         end
         S_Q_DONE: begin
            cmd.q_done = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/dynamic_pattern_set_occurrence_counter.sv
// Weighted pattern occurrence counter. Words carry an opcode (add, remove, query), a letter
// and a last flag; only a word with last set produces a response word. After reset the
// block clears its trie link and weight memories, one entry per cycle over all 131072 link
// entries, and accepts no word during that time. An add or remove letter passes a check
// state after the registered read of the trie link memory, unless the letter is skipped; a
// query letter is written straight to the text memory from the idle state. Finishing a
// pattern adds the weight read-modify-write in states S_WT_RD and S_WT_WR. A query's final
// walk steps through the trie from each start position by the chain of text, link and weight
// memory reads, with begin, done and output states to start it and load the response word.
module dynamic_pattern_set_occurrence_counter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [4:0]         req_letter,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_occurrence_total,
   output logic [1:0]         rsp_status
);
   import dpsoc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dpsoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dpsoc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_opcode           (req_opcode),
      .req_letter           (req_letter),
      .req_last             (req_last),
      .rsp_occurrence_total (rsp_occurrence_total),
      .rsp_status           (rsp_status)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

import dpsoc_pkg::*;

class occurrence_scoreboard;
   int unsigned   links[MAX_NODES][ALPHABET];
   int            weight[MAX_NODES];
   int unsigned   nodes_used;
   int unsigned   cursor;
   bit            blocked;
   logic [4:0]    text[MAX_TEXT];
   int unsigned   text_len;
   logic [1:0]    pending_err;
   logic signed [31:0] want_total[$];
   logic [1:0]    want_status[$];
   int            errors;
   int            checked;
   int            status_seen[4];

   function new();
      foreach (links[i, j]) links[i][j] = 0;
      foreach (weight[i]) weight[i] = 0;
      nodes_used = 1;
      cursor = 0;
      blocked = 0;
      text_len = 0;
      pending_err = STAT_OK;
      errors = 0;
      checked = 0;
   endfunction

   function int pending();
      return want_total.size();
   endfunction

   function longint occurrence_sum();
      longint sum;
      int unsigned node;
      int unsigned nxt;
      sum = 0;
      for (int unsigned s = 0; s < text_len; s++) begin
         node = 0;
         for (int unsigned p = s; p < text_len; p++) begin
            if (text[p] >= ALPHABET) break;
            nxt = links[node][text[p]];
            if (nxt == 0) break;
            node = nxt;
            sum += weight[node];
         end
      end
      return sum;
   endfunction

   function void note_word(logic [1:0] op, logic [4:0] letter, bit last);
      int unsigned nxt;
      int w;
      longint total;
      logic [1:0] stat;
      total = 0;
      if (op != OP_ADD && op != OP_REMOVE && op != OP_QUERY) return;
      if (op == OP_ADD || op == OP_REMOVE) begin
         if (!blocked && letter < ALPHABET) begin
            nxt = links[cursor][letter];
            if (nxt == 0) begin
               if (nodes_used >= MAX_NODES) begin
                  if (pending_err == STAT_OK) pending_err = STAT_POOL_FULL;
                  blocked = 1;
               end else begin
                  nxt = nodes_used;
                  nodes_used++;
                  links[cursor][letter] = nxt;
               end
            end
            if (!blocked) cursor = nxt;
         end
         if (!last) return;
         if (!blocked && pending_err == STAT_OK) begin
            w = weight[cursor] + ((op == OP_ADD) ? 1 : -1);
            if (w > 32767) w = 32767;
            if (w < -32768) w = -32768;
            weight[cursor] = w;
         end
         stat = pending_err;
         cursor = 0;
         blocked = 0;
      end else begin
         if (text_len >= MAX_TEXT) begin
            if (pending_err == STAT_OK) pending_err = STAT_TEXT_LONG;
         end else begin
            text[text_len] = letter;
            text_len++;
         end
         if (!last) return;
         stat = pending_err;
         if (stat == STAT_OK) total = occurrence_sum();
         text_len = 0;
      end
      pending_err = STAT_OK;
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      want_total.push_back(total[31:0]);
      want_status.push_back(stat);
   endfunction

   function void check_result(logic signed [31:0] total, logic [1:0] stat);
      logic signed [31:0] et;
      logic [1:0] es;
      if (want_total.size() == 0) begin
         $error("unexpected response word: total %0d status %0d", total, stat);
         errors++;
         return;
      end
      et = want_total.pop_front();
      es = want_status.pop_front();
      checked++;
      status_seen[es]++;
      if (total !== et) begin
         $error("occurrence_total: expected %0d, actual %0d", et, total);
         errors++;
      end
      if (stat !== es) begin
         $error("status: expected %0d, actual %0d", es, stat);
         errors++;
      end
   endfunction
endclass

module testbench;
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic [4:0]         req_letter;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_occurrence_total;
   logic [1:0]         rsp_status;

   occurrence_scoreboard sb = new();
   bit hold_rsp;
   int burst_left;
   int words_sent;

   dynamic_pattern_set_occurrence_counter uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_letter(req_letter),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_occurrence_total(rsp_occurrence_total),
      .rsp_status(rsp_status)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_occurrence_total, rsp_status);
   end

   initial begin
      int mode;
      int span;
      rsp_ready = 1'b0;
      mode = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
         end
         span--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= span[2];
         endcase
      end
   end

   task automatic send_word(logic [1:0] op, logic [4:0] letter, bit last);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_letter <= letter;
      req_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(op, letter, last);
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic send_string(logic [1:0] op, logic [4:0] s[$]);
      foreach (s[i]) send_word(op, s[i], i == s.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_traffic(int count);
      int r;
      int len;
      logic [4:0] s[$];
      while (count > 0) begin
         r = $urandom_range(0, 99);
         s = {};
         if (r < 40) begin
            len = $urandom_range(1, 4);
            repeat (len) s.push_back(($urandom_range(0, 9) == 0) ?
                                     5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3)));
            send_string($urandom_range(0, 3) == 0 ? OP_REMOVE : OP_ADD, s);
         end else if (r < 80) begin
            len = $urandom_range(1, 12);
            repeat (len) s.push_back(($urandom_range(0, 9) == 0) ?
                                     5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3)));
            send_string(OP_QUERY, s);
         end else if (r < 92) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               send_word(2'($urandom_range(0, 2)), 5'($urandom_range(0, 31)), i == len - 1);
         end else begin
            len = 1;
            send_word(2'd3, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            len = 0;
         end
         count -= len;
      end
   endtask

   initial begin
      #30ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_ADD;
      req_letter = 5'd0;
      req_last = 1'b0;
      hold_rsp = 0;
      words_sent = 0;
      burst_left = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_string(OP_ADD, '{5'd0, 5'd1});
      send_string(OP_ADD, '{5'd1});
      send_string(OP_ADD, '{5'd1});
      send_string(OP_QUERY, '{5'd0, 5'd1, 5'd0, 5'd1});
      send_string(OP_REMOVE, '{5'd1});
      send_string(OP_ADD, '{5'd25, 5'd31, 5'd0});
      send_string(OP_QUERY, '{5'd25, 5'd0, 5'd31, 5'd1});
      send_word(2'd3, 5'd31, 1'b1);
      send_word(OP_ADD, 5'd2, 1'b0);
      send_word(OP_QUERY, 5'd2, 1'b0);
      send_word(OP_REMOVE, 5'd3, 1'b1);
      send_word(OP_QUERY, 5'd3, 1'b1);
      send_string(OP_REMOVE, '{5'd9});
      send_string(OP_QUERY, '{5'd9, 5'd9});
      drain();

      random_traffic(280);

      hold_rsp = 1;
      for (int i = 0; i < 40; i++) send_word(OP_QUERY, 5'($urandom_range(0, 3)), 1'b1);
      drain();

      random_traffic(280);
      drain();

      random_traffic(280);
      drain();

      $display("Sent %0d words with random gaps and receiver stalls, one long hold included.",
               words_sent);
      $display("Checked %0d responses (status ok %0d, pool full %0d, text long %0d).",
               sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
